/* rtl/core/rws_pkg.sv */
// ----------------------------------------------------------------------------
// rws_pkg
// Widths, codes and constants shared by the roulette wheel selector files.
// ----------------------------------------------------------------------------
`default_nettype none

package rws_pkg;

  localparam int ACTION_W = 1;
  localparam int MEMBER_W = 3;
  localparam int FIT_W    = 17;
  localparam int DRAW_W   = 16;
  localparam int POP_W    = 4;

  // Fitness of 1.0 in unsigned 1.16 fixed point
  localparam logic [FIT_W-1:0] FIT_ONE = 17'd65536;

  localparam logic [POP_W-1:0] POP_RESET = 4'd8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD = 1'b0,
    ACT_DRAW = 1'b1
  } action_e;

endpackage

`default_nettype wire

/* rtl/core/rws_in_if.sv */
// ----------------------------------------------------------------------------
// rws_in_if
// Input channel of the selector: load or draw beats with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface rws_in_if;

  logic                          valid;
  logic                          ready;
  logic [rws_pkg::ACTION_W-1:0]  action;
  logic [rws_pkg::MEMBER_W-1:0]  member_index;
  logic [rws_pkg::FIT_W-1:0]     fitness_value;
  logic [rws_pkg::DRAW_W-1:0]    random_draw;

  modport source (
    output valid, action, member_index, fitness_value, random_draw,
    input  ready
  );

  modport sink (
    input  valid, action, member_index, fitness_value, random_draw,
    output ready
  );

endinterface

`default_nettype wire

/* rtl/core/rws_out_if.sv */
// ----------------------------------------------------------------------------
// rws_out_if
// Result channel of the selector: one chosen member per draw beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rws_out_if;

  logic                          valid;
  logic                          ready;
  logic [rws_pkg::MEMBER_W-1:0]  chosen_member;

  modport source (
    output valid, chosen_member,
    input  ready
  );

  modport sink (
    input  valid, chosen_member,
    output ready
  );

endinterface

`default_nettype wire

/* rtl/core/roulette_wheel_selector.sv */
// ----------------------------------------------------------------------------
// roulette_wheel_selector
// Fitness-proportional selection over a stored population held in one
// synchronous memory; a draw sums the fitnesses, scales the total by r and
// searches for the first cumulative fitness that crosses it.
// ----------------------------------------------------------------------------
//
//  channel     dir  handshake     payload
//  in_i        in   valid/ready   action, member_index, fitness_value,
//                                 random_draw
//  out_o       out  valid/ready   chosen_member
//  cfg_*_i     in   write enable  population_size (4 bits)
//
//  A load is written to the fitness memory as it is accepted. A draw runs
//  through these steps in order: the accept, reads of the fitness memory for
//  every member in use to sum the total, one multiply, reads for the search
//  up to every member in use and one step to post the result, all through
//  the single read port of the memory. The result is registered.
//  One item is in work at a time; loads are taken while a result waits.
//  A stalled result holds the next draw in its post state (S_PUSH).
//  Reset clears control state and sets population_size to 8; the fitness
//  memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module roulette_wheel_selector #(
  parameter int POP_MAX   = 8,
  parameter int FRAC_BITS = 16
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  rws_in_if.sink                     in_i,
  rws_out_if.source                  out_o,
  input  wire                        cfg_we_i,
  input  wire [rws_pkg::POP_W-1:0]   cfg_wdata_i
);

  localparam int IDX_W  = $clog2(POP_MAX);
  localparam int CNT_W  = $clog2(POP_MAX + 1);
  localparam int TOT_W  = rws_pkg::FIT_W + IDX_W;
  localparam int TGT_W  = TOT_W + rws_pkg::DRAW_W;
  localparam int CMP_W  = TOT_W + ((FRAC_BITS > rws_pkg::DRAW_W) ? FRAC_BITS
                                                                 : rws_pkg::DRAW_W);
  localparam int PW     = (CNT_W > rws_pkg::POP_W) ? CNT_W : rws_pkg::POP_W;
  localparam int MW     = (CNT_W > rws_pkg::MEMBER_W) ? CNT_W : rws_pkg::MEMBER_W;
  localparam logic [32:0] RMAX = (33'd1 << FRAC_BITS) - 33'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_MUL,
    S_SEARCH,
    S_PUSH
  } state_e;

  state_e                         state_q;
  logic                           out_vld_q;
  logic [rws_pkg::MEMBER_W-1:0]   out_member_q;
  logic [rws_pkg::POP_W-1:0]      pop_size_q;

  logic [rws_pkg::FIT_W-1:0]      fit_mem_q [POP_MAX];
  logic [rws_pkg::FIT_W-1:0]      rdata_q;

  logic [CNT_W-1:0]               cnt_q;
  logic [CNT_W-1:0]               n_q;
  logic [rws_pkg::DRAW_W-1:0]     r_q;
  logic [TOT_W-1:0]               total_q;
  logic [TOT_W-1:0]               cum_q;
  logic [TGT_W-1:0]               target_q;
  logic [rws_pkg::MEMBER_W-1:0]   res_q;

  logic                           in_acc;
  logic                           draw_acc;
  logic                           mem_we;
  logic [IDX_W-1:0]               waddr;
  logic [rws_pkg::FIT_W-1:0]      wdata;
  logic [IDX_W-1:0]               raddr;
  logic [PW-1:0]                  pop_ext;
  logic [CNT_W-1:0]               n_eff;
  logic [rws_pkg::DRAW_W-1:0]     r_sat;
  logic [TOT_W-1:0]               cum_d;
  logic                           hit;
  logic                           last;
  logic                           push_ok;

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_vld_q;
  assign out_o.chosen_member = out_member_q;

  always_comb begin
    in_acc   = in_i.valid && in_i.ready;
    draw_acc = in_acc && (in_i.action == rws_pkg::ACT_DRAW);
    // drop loads aimed past the store
    mem_we   = in_acc && (in_i.action == rws_pkg::ACT_LOAD) &&
               (MW'(in_i.member_index) < MW'(POP_MAX));
    waddr    = IDX_W'(in_i.member_index);
    wdata    = (in_i.fitness_value > rws_pkg::FIT_ONE) ? rws_pkg::FIT_ONE
                                                       : in_i.fitness_value;

    pop_ext = PW'(pop_size_q);
    if (pop_ext > PW'(POP_MAX)) begin
      n_eff = CNT_W'(POP_MAX);
    end else if (pop_ext == '0) begin
      n_eff = CNT_W'(1);
    end else begin
      n_eff = CNT_W'(pop_ext);
    end

    r_sat = (33'(in_i.random_draw) > RMAX) ? rws_pkg::DRAW_W'(RMAX)
                                           : in_i.random_draw;

    // the first read of a walk is issued from idle or from the multiply cycle
    if (state_q == S_IDLE || state_q == S_MUL) begin
      raddr = '0;
    end else begin
      raddr = cnt_q[IDX_W-1:0];
    end

    cum_d   = cum_q + TOT_W'(rdata_q);
    hit     = ((CMP_W'(cum_d) << FRAC_BITS) > CMP_W'(target_q));
    last    = (cnt_q == n_q);
    push_ok = !out_vld_q || out_o.ready;
  end

  // Fitness memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      fit_mem_q[waddr] <= wdata;
    end
    rdata_q <= fit_mem_q[raddr];
  end

  // Control state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_vld_q    <= 1'b0;
      out_member_q <= '0;
      pop_size_q   <= rws_pkg::POP_RESET;
    end else begin
      if (cfg_we_i) begin
        pop_size_q <= cfg_wdata_i;
      end
      // the post cycle sets valid itself
      if (out_vld_q && out_o.ready && (state_q != S_PUSH)) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (draw_acc) begin
            state_q <= S_SUM;
          end
        end
        S_SUM: begin
          if (last) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= (total_q == '0) ? S_PUSH : S_SEARCH;
        end
        S_SEARCH: begin
          if (hit || last) begin
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          // hold the result until the output beat slot is free
          if (push_ok) begin
            out_vld_q    <= 1'b1;
            out_member_q <= res_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath of a draw
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (draw_acc) begin
          r_q     <= r_sat;
          n_q     <= n_eff;
          cnt_q   <= CNT_W'(1);
          total_q <= '0;
        end
      end
      S_SUM: begin
        total_q <= total_q + TOT_W'(rdata_q);
        if (!last) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      S_MUL: begin
        target_q <= TGT_W'(r_q) * TGT_W'(total_q);
        cnt_q    <= CNT_W'(1);
        cum_q    <= '0;
        res_q    <= '0;
      end
      S_SEARCH: begin
        cum_q <= cum_d;
        if (hit) begin
          res_q <= rws_pkg::MEMBER_W'(cnt_q - CNT_W'(1));
        end else if (last) begin
          res_q <= rws_pkg::MEMBER_W'(n_q - CNT_W'(1));
        end else begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      S_PUSH: begin
        res_q <= res_q;
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

endmodule

`default_nettype wire

/* tb/rws_selection_checker.sv */
// ----------------------------------------------------------------------------
// rws_selection_checker
// Watches the load/draw and result channels of the selector. It keeps its
// own fitness store and population size, predicts the chosen member for
// every draw beat and compares each result beat against the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none

module rws_selection_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  rws_in_if                         in_mon,
  rws_out_if                        out_mon,
  input  logic                      cfg_we_i,
  input  logic [rws_pkg::POP_W-1:0] cfg_wdata_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  localparam int POP_MAX   = 8;
  localparam int FRAC_BITS = 16;
  localparam int SUM_W     = rws_pkg::FIT_W + 4;
  localparam int PROD_W    = SUM_W + FRAC_BITS;

  logic [rws_pkg::FIT_W-1:0]    fitness_q [POP_MAX];
  logic [rws_pkg::POP_W-1:0]    pop_q;
  logic [rws_pkg::MEMBER_W-1:0] chosen_q [$];
  int                           fail_count;

  // Scale the total by r rather than divide by it; first crossing wins
  function automatic logic [rws_pkg::MEMBER_W-1:0] select_member(
    input logic [rws_pkg::DRAW_W-1:0] r
  );
    int unsigned       in_use;
    logic [SUM_W-1:0]  total;
    logic [SUM_W-1:0]  cum;
    logic [PROD_W-1:0] target;
    in_use = (pop_q == '0) ? 1 : (pop_q > POP_MAX) ? POP_MAX : pop_q;
    total  = '0;
    for (int i = 0; i < in_use; i++) total += fitness_q[i];
    if (total == '0) return '0;
    target = r * total;
    cum    = '0;
    for (int i = 0; i < in_use; i++) begin
      cum += fitness_q[i];
      if ({cum, {FRAC_BITS{1'b0}}} > target) return rws_pkg::MEMBER_W'(i);
    end
    return rws_pkg::MEMBER_W'(in_use - 1);
  endfunction

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [rws_pkg::MEMBER_W-1:0] expected;
    if (!rst_ni) begin
      pop_q = rws_pkg::POP_RESET;
      chosen_q.delete();
      fail_count = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (rws_pkg::action_e'(in_mon.action) == rws_pkg::ACT_LOAD) begin
          // clamp fitness above one
          fitness_q[in_mon.member_index] =
            (in_mon.fitness_value > rws_pkg::FIT_ONE) ? rws_pkg::FIT_ONE
                                                      : in_mon.fitness_value;
        end else begin
          chosen_q.push_back(select_member(in_mon.random_draw));
        end
      end
      // a draw taken at this edge still sees the old size
      if (cfg_we_i) pop_q = cfg_wdata_i;
      if (out_mon.valid && out_mon.ready) begin
        if (chosen_q.size() == 0) begin
          note_failure($sformatf("unexpected beat: chosen_member %0d with nothing waiting",
                                 out_mon.chosen_member));
        end else begin
          expected = chosen_q.pop_front();
          if (out_mon.chosen_member !== expected) begin
            note_failure($sformatf("chosen_member mismatch: expected %0d, got %0d",
                                   expected, out_mon.chosen_member));
          end
        end
      end
      pending_o <= chosen_q.size();
      fail_count_o <= fail_count;
    end
  end

endmodule

`default_nettype wire

/* tb/roulette_wheel_selector_test.sv */
// ----------------------------------------------------------------------------
// roulette_wheel_selector_test
// Drives load and draw beats into the selector with random gaps and result
// stalls, steps the population size through its range between phases and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module roulette_wheel_selector_test;

  localparam int GAP_MAX      = 16;
  localparam int DRAIN_CYCLES = 24;
  localparam int PHASE_ITEMS  = 125;
  localparam int PHASES       = 14;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we;
  logic [rws_pkg::POP_W-1:0] cfg_wdata;
  int                        fail_count;
  int                        pending;

  int                        in_run;
  bit                        in_calm;
  int                        out_run;
  bit                        out_calm;
  int                        stall;

  logic [rws_pkg::POP_W-1:0] phase_pop [PHASES] = '{4'd8, 4'd1, 4'd15, 4'd2, 4'd0, 4'd5,
                                                   4'd8, 4'd3, 4'd12, 4'd7, 4'd1, 4'd4,
                                                   4'd6, 4'd8};

  rws_in_if  sel_in ();
  rws_out_if sel_out ();

  roulette_wheel_selector i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (sel_in),
    .out_o       (sel_out),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  rws_selection_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (sel_in),
    .out_mon      (sel_out),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Gap before the next beat; calm stretches run with no idling at all
  function automatic int pace(inout int run_left, inout bit calm);
    if (run_left == 0) begin
      calm     = ($urandom_range(0, 3) == 0);
      run_left = $urandom_range(8, 40);
    end
    run_left--;
    return calm ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  task automatic send_beat(input rws_pkg::action_e act,
                           input logic [rws_pkg::MEMBER_W-1:0] idx,
                           input logic [rws_pkg::FIT_W-1:0] fit,
                           input logic [rws_pkg::DRAW_W-1:0] r);
    int gap;
    gap = pace(in_run, in_calm);
    if (gap > 0) begin
      sel_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sel_in.valid         <= 1'b1;
    sel_in.action        <= act;
    sel_in.member_index  <= idx;
    sel_in.fitness_value <= fit;
    sel_in.random_draw   <= r;
    do @(posedge clk_i); while (!sel_in.ready);
  endtask

  task automatic load(input logic [rws_pkg::MEMBER_W-1:0] idx,
                      input logic [rws_pkg::FIT_W-1:0] fit);
    send_beat(rws_pkg::ACT_LOAD, idx, fit, rws_pkg::DRAW_W'($urandom()));
  endtask

  task automatic draw(input logic [rws_pkg::DRAW_W-1:0] r);
    send_beat(rws_pkg::ACT_DRAW, rws_pkg::MEMBER_W'($urandom()),
              rws_pkg::FIT_W'($urandom()), r);
  endtask

  // Drop valid and let every outstanding result and any load in flight finish
  task automatic drain();
    sel_in.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_population(input logic [rws_pkg::POP_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_phase(input int items);
    int                         c;
    logic [rws_pkg::FIT_W-1:0]  fit;
    logic [rws_pkg::DRAW_W-1:0] r;
    for (int k = 0; k < items; k++) begin
      c = $urandom_range(0, 9);
      if ($urandom_range(0, 9) < 4) begin
        case (c)
          0:       fit = '0;
          1:       fit = rws_pkg::FIT_ONE;
          2:       fit = rws_pkg::FIT_W'($urandom_range(65537, 131071));
          3:       fit = rws_pkg::FIT_W'($urandom_range(0, 255));
          default: fit = rws_pkg::FIT_W'($urandom_range(0, 65536));
        endcase
        load(rws_pkg::MEMBER_W'($urandom_range(0, 7)), fit);
      end else begin
        case (c)
          0:       r = '0;
          1:       r = '1;
          default: r = rws_pkg::DRAW_W'($urandom());
        endcase
        draw(r);
      end
    end
  endtask

  // Result side: hold ready low for a drawn stall, then wait for a beat
  initial begin
    sel_out.ready = 1'b0;
    out_run  = 0;
    out_calm = 1'b0;
    forever begin
      stall = pace(out_run, out_calm);
      if (stall > 0) begin
        sel_out.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      sel_out.ready <= 1'b1;
      do @(posedge clk_i); while (!sel_out.valid);
    end
  end

  initial begin
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    sel_in.valid         = 1'b0;
    sel_in.action        = rws_pkg::ACT_LOAD;
    sel_in.member_index  = '0;
    sel_in.fitness_value = '0;
    sel_in.random_draw   = '0;
    in_run               = 0;
    in_calm              = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the whole store before any draw, with saturating values among them
    load(3'd0, rws_pkg::FIT_ONE);
    load(3'd1, 17'd0);
    load(3'd2, 17'h1FFFF);
    load(3'd3, 17'd1);
    load(3'd4, 17'd32768);
    load(3'd5, 17'd65535);
    load(3'd6, 17'd65537);
    load(3'd7, 17'd291);
    draw(16'h0000);
    draw(16'hFFFF);
    draw(16'h8000);
    draw(16'h0001);

    // Single member, zero total then a non-zero one
    set_population(4'd1);
    load(3'd0, 17'd0);
    draw(16'hFFFF);
    draw(16'h0000);
    load(3'd0, 17'd100);
    draw(16'h7FFF);

    // Size zero acts as one, oversize acts as the full store
    set_population(4'd0);
    draw(16'h1234);
    set_population(4'd15);
    draw(16'h0000);
    draw(16'hFFFF);
    draw(16'h4321);

    for (int p = 0; p < PHASES; p++) begin
      set_population(phase_pop[p]);
      random_phase(PHASE_ITEMS);
    end

    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
